// ----- rtl/core/tremolo_lfo_modulator_defines.svh -----
// Assertion macros shared by the tremolo LFO modulator RTL.
`ifndef TREMOLO_LFO_MODULATOR_DEFINES_SVH
`define TREMOLO_LFO_MODULATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TLM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tlm_pkg.sv -----
// Types and constants of the tremolo LFO modulator.
package tlm_pkg;

	localparam int CTRL_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int STEP_W   = 24;
	localparam int PHASE_W  = 32;
	localparam int AMP_W    = 17;
	localparam int FREQ_W   = 26;
	localparam int QW_AMP   = 16;
	localparam int QW_FREQ  = 26;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CHANNELS = 2;

	localparam logic [AMP_W-1:0]  AMP_ONE   = 17'd65536;
	localparam logic [FREQ_W-1:0] FREQ_BASE = 26'(100 * 65536);
	localparam logic [FREQ_W-1:0] FREQ_MIN  = 26'(50 * 65536);
	localparam logic [FREQ_W-1:0] FREQ_MAX  = 26'(1000 * 65536);
	localparam logic [FREQ_W-1:0] FREQ_DROP = 26'(50 * 65536);
	localparam logic [9:0]        FREQ_SPAN_HZ = 10'd900;

	localparam logic [CTRL_W-1:0] RST_RATE_LOW  = 16'd655;
	localparam logic [CTRL_W-1:0] RST_RATE_HIGH = 16'd28836;
	localparam logic [CTRL_W-1:0] RST_GAIN_LOW  = 16'd9861;
	localparam logic [CTRL_W-1:0] RST_GAIN_HIGH = 16'd19661;
	localparam logic [STEP_W-1:0] RST_STEP      = 24'd97392;

	// quarter-wave sine polynomial, Q30, Horner order
	localparam logic signed [31:0] POLY_INIT = 32'sd172272;
	localparam logic signed [31:0] POLY_COEF [4] = '{
		-32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE_LOW  = 3'd0,
		REG_RATE_HIGH = 3'd1,
		REG_GAIN_LOW  = 3'd2,
		REG_GAIN_HIGH = 3'd3,
		REG_STEP      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CTRL_W-1:0]          rate_reading;
		logic [CTRL_W-1:0]          gain_reading;
		logic signed [SAMPLE_W-1:0] sample_left;
		logic signed [SAMPLE_W-1:0] sample_right;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] result_left;
		logic signed [SAMPLE_W-1:0] result_right;
	} out_word_t;

endpackage

// ----- rtl/core/tlm_div.sv -----
// Restoring divider, two quotient bits per cycle, dividend top part below divisor.
`include "tremolo_lfo_modulator_defines.svh"
module tlm_div #(
	parameter int QW = 16,
	parameter int DW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW+QW-1:0] dividend,
	input  logic [DW-1:0]    divisor,
	output logic             done,
	output logic [QW-1:0]    quotient
);
	localparam int STEPS = QW / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DW-1:0]    rem_q, den_q, rem_nx;
	logic [QW-1:0]    sh_q, sh_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	always_comb begin
		logic [DW:0] t;
		rem_nx = rem_q;
		sh_nx  = sh_q;
		for (int k = 0; k < 2; k++) begin
			t     = {rem_nx, sh_nx[QW-1]};
			sh_nx = {sh_nx[QW-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				rem_nx   = DW'(t - {1'b0, den_q});
				sh_nx[0] = 1'b1;
			end else begin
				rem_nx = t[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DW+QW-1:QW];
			sh_q  <= dividend[QW-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			sh_q  <= sh_nx;
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

	`TLM_ASSERT_NEXT(a_div_start_clears, start, !done_q, "divider done survived a start")
	`TLM_ASSERT_SAME(a_div_busy_excl, busy_q, !done_q, "divider busy and done together")
	`TLM_ASSERT_NEXT(a_div_hold, done_q && !start, done_q && $stable(sh_q),
		"divider quotient moved after done")
endmodule

// ----- rtl/core/tlm_sine_rom.sv -----
// Sine table memory, filled after reset by a polynomial sequencer on one multiplier.
module tlm_sine_rom #(
	parameter int DEPTH = 1024,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_W-1:0]    rd_addr,
	output logic signed [15:0]  rd_data,
	output logic                ready
);
	import tlm_pkg::*;

	localparam int N_W = $clog2(DEPTH + 1);
	localparam longint unsigned TURN = 64'd1 << 32;
	localparam logic [31:0]    STEP_Q = 32'(TURN / DEPTH);
	localparam logic [N_W-1:0] STEP_R = N_W'(TURN % DEPTH);
	localparam logic [N_W:0]   DEPTH_C = (N_W + 1)'(DEPTH);
	localparam logic [31:0]    Q30 = 32'd1 << 30;

	typedef enum logic [6:0] {
		F_T2   = 7'b0000001,
		F_P0   = 7'b0000010,
		F_MUL  = 7'b0000100,
		F_ACC  = 7'b0001000,
		F_FIN  = 7'b0010000,
		F_SC   = 7'b0100000,
		F_DONE = 7'b1000000
	} fill_state_t;

	function automatic logic signed [63:0] div_q30(input logic signed [63:0] x);
		logic signed [63:0] r;
		r = x >>> 30;
		if (x[63] && (x[29:0] != '0))
			r = r + 64'sd1;
		return r;
	endfunction

	fill_state_t       state_q;
	logic [31:0]       tq_q;
	logic [N_W-1:0]    tr_q, rem_q;
	logic [1:0]        quad_q, k_q;
	logic [IDX_W-1:0]  addr_q;
	logic signed [31:0] t_q, t2_q, p_q, mul_a, mul_b, t_cur;
	logic signed [63:0] prod_q, s_full, v_full;
	logic signed [15:0] sine_val;
	logic [N_W:0]      tr_sum, rem_sum;
	logic              carry, wrap;
	logic [31:0]       tq_sum;

	logic signed [15:0] mem [DEPTH];

	assign t_cur = quad_q[0] ? $signed(Q30 - tq_q) : $signed(tq_q);

	always_comb begin
		case (state_q)
			F_T2: begin
				mul_a = t_cur;
				mul_b = t_cur;
			end
			F_MUL: begin
				mul_a = p_q;
				mul_b = t2_q;
			end
			F_FIN: begin
				mul_a = p_q;
				mul_b = t_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		s_full = div_q30(prod_q);
		if (s_full < 0)
			s_full = '0;
		v_full = ((s_full <<< 15) - s_full + 64'sd536870912) >>> 30;
		if (v_full > 64'sd32767)
			v_full = 64'sd32767;
		sine_val = quad_q[1] ? -16'(v_full) : 16'(v_full);
	end

	assign tr_sum  = {1'b0, tr_q} + {1'b0, STEP_R};
	assign carry   = tr_sum >= DEPTH_C;
	assign rem_sum = {1'b0, rem_q} + (N_W + 1)'(4);
	assign wrap    = rem_sum >= DEPTH_C;
	assign tq_sum  = tq_q + STEP_Q + 32'(carry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_T2;
			tq_q    <= '0;
			tr_q    <= '0;
			rem_q   <= '0;
			quad_q  <= '0;
			k_q     <= '0;
			addr_q  <= '0;
		end else begin
			case (state_q)
				F_T2: state_q <= F_P0;
				F_P0: begin
					k_q     <= '0;
					state_q <= F_MUL;
				end
				F_MUL: state_q <= F_ACC;
				F_ACC: begin
					k_q     <= k_q + 1'b1;
					state_q <= (k_q == 2'd3) ? F_FIN : F_MUL;
				end
				F_FIN: state_q <= F_SC;
				F_SC: begin
					tr_q   <= carry ? N_W'(tr_sum - DEPTH_C) : tr_sum[N_W-1:0];
					tq_q   <= wrap ? tq_sum - Q30 : tq_sum;
					rem_q  <= wrap ? N_W'(rem_sum - DEPTH_C) : rem_sum[N_W-1:0];
					quad_q <= quad_q + 2'(wrap);
					addr_q <= addr_q + 1'b1;
					state_q <= (addr_q == IDX_W'(DEPTH - 1)) ? F_DONE : F_T2;
				end
				F_DONE: state_q <= F_DONE;
				default: state_q <= F_T2;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			F_T2: t_q <= t_cur;
			F_P0: begin
				t2_q <= 32'(div_q30(prod_q));
				p_q  <= POLY_INIT;
			end
			F_ACC: p_q <= 32'(POLY_COEF[k_q] + div_q30(prod_q));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == F_SC)
			mem[addr_q] <= sine_val;
		rd_data <= mem[rd_addr];
	end

	assign ready = state_q == F_DONE;
endmodule

// ----- rtl/core/tlm_lane.sv -----
// One channel lane: sample times sine, times amplitude, rounded and saturated.
module tlm_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tlm_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [15:0]                 sine,
	input  logic [tlm_pkg::AMP_W-1:0]          amp,
	output logic                               done,
	output logic signed [tlm_pkg::SAMPLE_W-1:0] result
);
	import tlm_pkg::*;

	logic signed [31:0]       prod_s1;
	logic [AMP_W-1:0]         amp_s1;
	logic signed [49:0]       prod_s2, rnd;
	logic signed [16:0]       y;
	logic signed [SAMPLE_W-1:0] res_s3;
	logic                     valid_s1, valid_s2, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			if (start)
				done_q <= 1'b0;
			else if (valid_s2)
				done_q <= 1'b1;
		end
	end

	assign rnd = prod_s2 + (50'sd1 <<< 32);
	assign y   = 17'(rnd >>> 33);

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= sample * sine;
			amp_s1  <= amp;
		end
		if (valid_s1)
			prod_s2 <= prod_s1 * $signed({1'b0, amp_s1});
		if (valid_s2) begin
			if (y > 17'sd32767)
				res_s3 <= 16'sh7fff;
			else if (y < -17'sd32768)
				res_s3 <= -16'sh8000;
			else
				res_s3 <= 16'(y);
		end
	end

	assign done   = done_q;
	assign result = res_s3;
endmodule

// ----- rtl/core/tremolo_lfo_modulator.sv -----
// From an accepted input word to its output word, the 26-bit rate divider (two quotient
// bits per cycle) sets most of the latency. One word is in flight at a time, so a new word
// is taken only once the last one is done; a finished word waits in the output register
// and holds the next one back while out_ready is low.
// After reset the sine table is filled while in_ready is low; configuration writes are taken
// throughout. Reset clears the LFO phase and loads defaults.
`include "tremolo_lfo_modulator_defines.svh"
module tremolo_lfo_modulator #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tlm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [tlm_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tlm_pkg::in_word_t              in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output tlm_pkg::out_word_t             out_word
);
	import tlm_pkg::*;

	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int IP_W  = PHASE_W + IDX_W + 1;

	typedef enum logic [6:0] {
		S_FILL  = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_PREP  = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_INC   = 7'b0010000,
		S_PHASE = 7'b0100000,
		S_LANE  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		AMP_ZERO = 2'd0,
		AMP_FULL = 2'd1,
		AMP_DIV  = 2'd2
	} amp_mode_t;

	typedef enum logic [1:0] {
		FRQ_BASE = 2'd0,
		FRQ_LOW  = 2'd1,
		FRQ_HIGH = 2'd2,
		FRQ_DIV  = 2'd3
	} freq_mode_t;

	state_t            state_q;
	amp_mode_t         amp_mode_q, amp_mode;
	freq_mode_t        freq_mode_q, freq_mode;
	logic              freq_neg_q;
	in_word_t          item_q;
	out_word_t         out_q;
	logic              out_valid_q;

	logic [CTRL_W-1:0] rate_low_q, rate_high_q, gain_low_q, gain_high_q;
	logic [STEP_W-1:0] step_q;
	logic [PHASE_W-1:0] phase_q, inc_q;
	logic [AMP_W-1:0]  amp_q;
	logic [FREQ_W-1:0] freq_q, freq_div_val;
	logic [IDX_W-1:0]  idx_q;
	logic [IP_W-1:0]   idx_prod;
	logic [FREQ_W+STEP_W-1:0] inc_prod;

	logic signed [16:0] g_num, g_den, g_n, r_num, r_den, r_n;
	logic [CTRL_W-1:0]  g_d, r_d, r_abs;
	logic               r_neg;
	logic [FREQ_W-1:0]  prod900;

	logic               rom_ready, div_amp_done, div_freq_done, div_start, lanes_done;
	logic signed [15:0] sine;
	logic [QW_AMP-1:0]  q_amp;
	logic [QW_FREQ-1:0] q_freq;

	logic signed [SAMPLE_W-1:0] lane_sample [CHANNELS];
	logic signed [SAMPLE_W-1:0] lane_res [CHANNELS];
	logic [CHANNELS-1:0]        lane_done;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_low_q  <= RST_RATE_LOW;
			rate_high_q <= RST_RATE_HIGH;
			gain_low_q  <= RST_GAIN_LOW;
			gain_high_q <= RST_GAIN_HIGH;
			step_q      <= RST_STEP;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_RATE_LOW:  rate_low_q  <= wr_data[CTRL_W-1:0];
				REG_RATE_HIGH: rate_high_q <= wr_data[CTRL_W-1:0];
				REG_GAIN_LOW:  gain_low_q  <= wr_data[CTRL_W-1:0];
				REG_GAIN_HIGH: gain_high_q <= wr_data[CTRL_W-1:0];
				REG_STEP:      step_q      <= wr_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// map ends normalised so that the slope is positive
	always_comb begin
		g_num = $signed({1'b0, item_q.gain_reading}) - $signed({1'b0, gain_low_q});
		g_den = $signed({1'b0, gain_high_q}) - $signed({1'b0, gain_low_q});
		g_n   = g_den[16] ? -g_num : g_num;
		g_d   = g_den[16] ? CTRL_W'(-g_den) : g_den[CTRL_W-1:0];
		if (g_den == '0)
			amp_mode = AMP_ZERO;
		else if (g_n[16] || (g_n == '0))
			amp_mode = AMP_ZERO;
		else if (g_n[CTRL_W-1:0] >= g_d)
			amp_mode = AMP_FULL;
		else
			amp_mode = AMP_DIV;

		r_num = $signed({1'b0, item_q.rate_reading}) - $signed({1'b0, rate_low_q});
		r_den = $signed({1'b0, rate_high_q}) - $signed({1'b0, rate_low_q});
		r_n   = r_den[16] ? -r_num : r_num;
		r_d   = r_den[16] ? CTRL_W'(-r_den) : r_den[CTRL_W-1:0];
		r_neg = r_n[16];
		r_abs = r_neg ? CTRL_W'(-r_n) : r_n[CTRL_W-1:0];
		if (r_den == '0)
			freq_mode = FRQ_BASE;
		else if (r_abs >= r_d)
			freq_mode = r_neg ? FRQ_LOW : FRQ_HIGH;
		else
			freq_mode = FRQ_DIV;
		prod900 = FREQ_W'(r_abs) * FREQ_W'(FREQ_SPAN_HZ);
	end

	assign div_start = state_q == S_PREP;

	tlm_div #(.QW(QW_AMP), .DW(CTRL_W)) u_div_amp (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({g_n[CTRL_W-1:0], {QW_AMP{1'b0}}}),
		.divisor  (g_d),
		.done     (div_amp_done),
		.quotient (q_amp)
	);

	tlm_div #(.QW(QW_FREQ), .DW(CTRL_W)) u_div_freq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({prod900, {CTRL_W{1'b0}}}),
		.divisor  (r_d),
		.done     (div_freq_done),
		.quotient (q_freq)
	);

	always_comb begin
		if (freq_neg_q)
			freq_div_val = (q_freq > FREQ_DROP) ? FREQ_MIN : FREQ_BASE - q_freq;
		else
			freq_div_val = FREQ_BASE + q_freq;
	end

	// table index follows the phase; sine read is registered
	assign idx_prod = IP_W'(phase_q) * IP_W'(SINE_TABLE_DEPTH);
	always_ff @(posedge clk)
		idx_q <= idx_prod[PHASE_W +: IDX_W];

	tlm_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (idx_q),
		.rd_data (sine),
		.ready   (rom_ready)
	);

	assign lane_sample[0] = item_q.sample_left;
	assign lane_sample[1] = item_q.sample_right;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		tlm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == S_INC),
			.sample (lane_sample[c]),
			.sine   (sine),
			.amp    (amp_q),
			.done   (lane_done[c]),
			.result (lane_res[c])
		);
	end

	assign lanes_done = &lane_done;
	assign inc_prod   = FREQ_W'(freq_q) * (FREQ_W + STEP_W)'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
			amp_mode_q  <= AMP_ZERO;
			freq_mode_q <= FRQ_BASE;
			freq_neg_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_FILL: if (rom_ready) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_PREP;
				S_PREP: begin
					amp_mode_q  <= amp_mode;
					freq_mode_q <= freq_mode;
					freq_neg_q  <= r_neg;
					state_q     <= S_DIV;
				end
				S_DIV: if (div_amp_done && div_freq_done) state_q <= S_INC;
				S_INC: state_q <= S_PHASE;
				S_PHASE: begin
					phase_q <= phase_q + inc_q;
					state_q <= S_LANE;
				end
				S_LANE: begin
					if (lanes_done && (!out_valid_q || out_ready)) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_FILL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			item_q <= in_word;
		if (state_q == S_DIV && div_amp_done && div_freq_done) begin
			case (amp_mode_q)
				AMP_FULL: amp_q <= AMP_ONE;
				AMP_DIV:  amp_q <= {1'b0, q_amp};
				default:  amp_q <= '0;
			endcase
			case (freq_mode_q)
				FRQ_LOW:  freq_q <= FREQ_MIN;
				FRQ_HIGH: freq_q <= FREQ_MAX;
				FRQ_DIV:  freq_q <= freq_div_val;
				default:  freq_q <= FREQ_BASE;
			endcase
		end
		if (state_q == S_INC)
			inc_q <= inc_prod[16 +: PHASE_W];
		if (state_q == S_LANE && lanes_done && (!out_valid_q || out_ready)) begin
			out_q.result_left  <= lane_res[0];
			out_q.result_right <= lane_res[1];
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`TLM_ASSERT_SAME(a_no_early_accept, in_valid && in_ready, rom_ready,
		"word accepted before the sine table was filled")
	`TLM_ASSERT_NEXT(a_phase_hold, state_q != S_PHASE, $stable(phase_q),
		"LFO phase moved outside its update step")
	`TLM_ASSERT_NEXT(a_out_load, state_q == S_LANE && lanes_done && (!out_valid_q || out_ready),
		out_valid_q && state_q == S_IDLE, "finished word not loaded into the output register")
endmodule

// ----- tb/tlm_checker.sv -----
// Checker for the tremolo LFO modulator: predicts each result word and compares it.
`timescale 1ns / 1ps

module tlm_checker #(
	parameter int LUT_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tlm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [tlm_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  tlm_pkg::in_word_t              in_word,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  tlm_pkg::out_word_t             out_word,
	output int                             mismatches,
	output int                             outstanding,
	output int                             frames_in,
	output int                             words_checked
);
	import tlm_pkg::*;

	typedef longint unsigned u64_t;

	localparam longint Q30        = 64'sd1073741824;
	localparam longint AMP_UNITY  = 64'sd65536;
	localparam longint HZ_Q16     = 64'sd65536;
	localparam longint F_BASE     = 100 * HZ_Q16;
	localparam longint F_SPAN     = 900 * HZ_Q16;
	localparam longint F_FLOOR    = 50 * HZ_Q16;
	localparam longint F_CEIL     = 1000 * HZ_Q16;
	localparam longint ROUND_HALF = 64'sd1 << 32;

	bit [15:0]               rate_lo, rate_hi, gain_lo, gain_hi;
	bit [23:0]               phase_inc_per_hz;
	bit [31:0]               lfo_phase;
	logic signed [15:0]      sine_lut [LUT_DEPTH];
	out_word_t               expected_words [$];

	function automatic longint quarter_sine(longint t);
		longint t2, p;
		t2 = t * t / Q30;
		p = 172272;
		p = -5026995 + p * t2 / Q30;
		p = 85569306 + p * t2 / Q30;
		p = -693598668 + p * t2 / Q30;
		p = 1686629713 + p * t2 / Q30;
		p = p * t / Q30;
		return (p < 0) ? 0 : p;
	endfunction

	initial begin : lut_fill
		longint quad, rem, t, v;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			quad = (4 * longint'(i)) / LUT_DEPTH;
			rem = 4 * longint'(i) - quad * LUT_DEPTH;
			t = rem * Q30 / LUT_DEPTH;
			if (quad % 2 == 1)
				t = Q30 - t;
			v = (quarter_sine(t) * 32767 + Q30 / 2) / Q30;
			if (v > 32767)
				v = 32767;
			sine_lut[i] = 16'((quad >= 2) ? -v : v);
		end
	end

	function automatic longint gain_to_amp(bit [15:0] g);
		longint num, den;
		num = longint'(g) - longint'(gain_lo);
		den = longint'(gain_hi) - longint'(gain_lo);
		if (den == 0)
			return 0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num <= 0)
			return 0;
		if (num >= den)
			return AMP_UNITY;
		return num * AMP_UNITY / den;
	endfunction

	function automatic longint rate_to_freq(bit [15:0] r);
		longint num, den, f, mag;
		num = longint'(r) - longint'(rate_lo);
		den = longint'(rate_hi) - longint'(rate_lo);
		f = F_BASE;
		if (den != 0) begin
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			mag = ((num < 0) ? -num : num) * F_SPAN / den;
			f += (num < 0) ? -mag : mag;
		end
		if (f < F_FLOOR)
			f = F_FLOOR;
		if (f > F_CEIL)
			f = F_CEIL;
		return f;
	endfunction

	function automatic logic signed [15:0] scale_sample(longint x, longint sine, longint amp);
		longint y;
		y = (x * sine * amp + ROUND_HALF) >>> 33;
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return y[15:0];
	endfunction

	function automatic out_word_t tremolo_frame(in_word_t w);
		out_word_t r;
		bit [63:0] idx;
		longint amp, sine;
		amp = gain_to_amp(w.gain_reading);
		idx = ({32'b0, lfo_phase} * LUT_DEPTH) >> 32;
		if (idx >= LUT_DEPTH)
			idx = LUT_DEPTH - 1;
		sine = sine_lut[int'(idx)];
		r.result_left = scale_sample(w.sample_left, sine, amp);
		r.result_right = scale_sample(w.sample_right, sine, amp);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t want;
		u64_t freq, inc;
		if (!arst_n) begin
			rate_lo = 16'd655;
			rate_hi = 16'd28836;
			gain_lo = 16'd9861;
			gain_hi = 16'd19661;
			phase_inc_per_hz = 24'd97392;
			lfo_phase = '0;
			expected_words.delete();
			mismatches = 0;
			frames_in = 0;
			words_checked = 0;
			outstanding <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_RATE_LOW:  rate_lo = wr_data[15:0];
					REG_RATE_HIGH: rate_hi = wr_data[15:0];
					REG_GAIN_LOW:  gain_lo = wr_data[15:0];
					REG_GAIN_HIGH: gain_hi = wr_data[15:0];
					REG_STEP:      phase_inc_per_hz = wr_data[23:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				expected_words.push_back(tremolo_frame(in_word));
				freq = u64_t'(rate_to_freq(in_word.rate_reading));
				inc = (freq * phase_inc_per_hz) >> 16;
				lfo_phase = lfo_phase + inc[31:0];
				frames_in++;
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with no frame outstanding: result_left %0d, result_right %0d",
						out_word.result_left, out_word.result_right);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (out_word.result_left !== want.result_left) begin
						$error("result_left: expected %0d, got %0d",
							want.result_left, out_word.result_left);
						mismatches++;
					end
					if (out_word.result_right !== want.result_right) begin
						$error("result_right: expected %0d, got %0d",
							want.result_right, out_word.result_right);
						mismatches++;
					end
					words_checked++;
				end
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the tremolo LFO modulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import tlm_pkg::*;

	localparam int LUT_DEPTH  = 1024;
	localparam int IDLE_LIMIT = 50000;
	localparam int TAIL       = 30;

	localparam bit [15:0] DIR_RATE [4]   = '{16'd0, 16'd655, 16'd28836, 16'd14000};
	localparam bit [15:0] DIR_GAIN [7]   = '{16'hFFFF, 16'h0000, 16'd9861, 16'd19661,
		16'd14761, 16'd19660, 16'd9862};
	localparam bit [15:0] DIR_SAMPLE [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  in_valid;
	logic                  in_ready;
	in_word_t              in_word;
	logic                  out_valid;
	logic                  out_ready;
	out_word_t             out_word;

	int        mismatches, outstanding, frames_in, words_checked;
	int        settings_used;
	int        idle_cycles = 0;
	bit        steady;
	bit [15:0] rate_lo, rate_hi, gain_lo, gain_hi;

	tremolo_lfo_modulator #(
		.SINE_TABLE_DEPTH(LUT_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	tlm_checker #(
		.LUT_DEPTH(LUT_DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_word      (in_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_word     (out_word),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.frames_in    (frames_in),
		.words_checked(words_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic bit [15:0] pick_reading(bit [15:0] lo, bit [15:0] hi);
		bit [15:0] base;
		case ($urandom_range(0, 5))
			0, 1: return 16'($urandom);
			2, 3: return 16'($urandom_range(lo, hi));
			4: begin
				base = $urandom_range(0, 1) ? lo : hi;
				return base + 16'($urandom_range(0, 6)) - 16'd3;
			end
			default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	function automatic bit [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_word_t random_frame();
		in_word_t w;
		w.rate_reading = pick_reading(rate_lo, rate_hi);
		w.gain_reading = pick_reading(gain_lo, gain_hi);
		w.sample_left = pick_sample();
		w.sample_right = pick_sample();
		return w;
	endfunction

	initial begin : result_sink
		int run, g;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			run = steady ? 64 : $urandom_range(1, 16);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	task automatic send_word(in_word_t w);
		int g;
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic run_frames(int n);
		for (int i = 0; i < n; i++) begin
			send_word(random_frame());
			if ($urandom_range(0, 49) == 0)
				wait_for_results();
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// upper data bits carry junk on the 16-bit registers
	task automatic apply_settings(bit [15:0] rl, bit [15:0] rh, bit [15:0] gl, bit [15:0] gh,
		bit [23:0] step);
		wait_for_results();
		write_reg(REG_RATE_LOW, {8'($urandom), rl});
		write_reg(REG_RATE_HIGH, {8'($urandom), rh});
		write_reg(REG_GAIN_LOW, {8'($urandom), gl});
		write_reg(REG_GAIN_HIGH, {8'($urandom), gh});
		write_reg(REG_STEP, step);
		wr_en <= 1'b0;
		rate_lo = rl;
		rate_hi = rh;
		gain_lo = gl;
		gain_hi = gh;
		settings_used++;
	endtask

	initial begin : stimulus
		bit [15:0] a, b, c, d;
		in_word_t  w;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		steady = 1'b0;
		rate_lo = RST_RATE_LOW;
		rate_hi = RST_RATE_HIGH;
		gain_lo = RST_GAIN_LOW;
		gain_hi = RST_GAIN_HIGH;
		settings_used = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings; fast LFO first so the sine leaves zero
		for (int k = 0; k < 22; k++) begin
			w.rate_reading = (k < 14) ? 16'hFFFF : DIR_RATE[k % 4];
			w.gain_reading = DIR_GAIN[k % 7];
			w.sample_left = DIR_SAMPLE[k % 5];
			w.sample_right = DIR_SAMPLE[(k + 2) % 5];
			send_word(w);
		end
		run_frames(120);

		a = 16'($urandom_range(0, 30000));
		c = 16'($urandom_range(0, 30000));
		apply_settings(a, 16'($urandom_range(a + 1, 65535)), c,
			16'($urandom_range(c + 1, 65535)), 24'($urandom_range(20000, 400000)));
		run_frames(120);

		// equal map ends
		steady = 1'b1;
		a = 16'($urandom);
		c = 16'($urandom);
		apply_settings(a, a, c, c, 24'($urandom_range(20000, 400000)));
		run_frames(60);
		steady = 1'b0;

		// reversed ends, largest phase step
		a = 16'($urandom_range(0, 30000));
		c = 16'($urandom_range(0, 30000));
		apply_settings(16'($urandom_range(a + 1, 65535)), a, 16'($urandom_range(c + 1, 65535)), c,
			24'hFFFFFF);
		run_frames(100);

		steady = 1'b1;
		apply_settings(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 24'd1);
		run_frames(60);
		steady = 1'b0;

		// reversed full scale, LFO frozen, writes to unused indexes
		apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 24'd0);
		for (int k = int'(REG_STEP) + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
		wr_en <= 1'b0;
		run_frames(60);

		// narrow ends: readings far off drive both clamps
		apply_settings(16'd30000, 16'd30100, 16'd40000, 16'd40001,
			24'($urandom_range(20000, 400000)));
		run_frames(80);

		repeat (4) begin
			a = 16'($urandom);
			b = 16'($urandom);
			c = 16'($urandom);
			d = 16'($urandom);
			if ($urandom_range(0, 9) == 0)
				b = a;
			apply_settings(a, b, c, d, ($urandom_range(0, 3) == 0) ? 24'($urandom)
				: 24'($urandom_range(30000, 300000)));
			run_frames(60);
		end

		wait_for_results();
		repeat (TAIL) @(posedge clk);
		$display("Sent %0d audio frames over %0d register settings: equal, reversed and full-scale",
			frames_in, settings_used);
		$display("map ends, zero and maximum phase step; %0d result words checked, %0d mismatches.",
			words_checked, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- tremolo_lfo_modulator.f -----
+incdir+rtl/core
rtl/core/tlm_pkg.sv
rtl/core/tlm_div.sv
rtl/core/tlm_sine_rom.sv
rtl/core/tlm_lane.sv
rtl/core/tremolo_lfo_modulator.sv
tb/tlm_checker.sv
tb/tb_top.sv
